FILE: sv/sshit_pkg.sv
`timescale 1ns / 1ps

package sshit_pkg;

    localparam int DEF_MAX_NODES = 4096;
    localparam int CFG_W         = 13;
    localparam int PADDR_W       = 2;

    localparam logic [PADDR_W-1:0] ADDR_NODES_IN_USE = 2'd0;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSQ,
        S_DEN,
        S_CHECK,
        S_RUN,
        S_DRAIN,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath and the output stage.
    typedef struct packed {
        logic load_we;
        logic start;
        logic dsq_en;
        logic den_en;
        logic issue;
        logic resp;
        logic resp_zero;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic pipe_busy;
        logic hit;
    } t_sts;

endpackage

FILE: sv/sshit_if.sv
`timescale 1ns / 1ps

interface sshit_in_if;
    logic              valid;
    logic              ready;
    logic [0:0]        opcode;
    logic [11:0]       node_index;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]       sphere_radius;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source (
        output valid, opcode, node_index, centre_x, centre_y, centre_z, sphere_radius,
               start_x, start_y, start_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, node_index, centre_x, centre_y, centre_z, sphere_radius,
               start_x, start_y, start_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

interface sshit_out_if;
    logic valid;
    logic ready;
    logic hit;
    logic zero_length;

    modport source (output valid, hit, zero_length, input ready);
    modport sink (input valid, hit, zero_length, output ready);
endinterface

FILE: sv/sshit_ctrl.sv
`timescale 1ns / 1ps

module sshit_ctrl #(
    parameter int MAX_NODES = sshit_pkg::DEF_MAX_NODES,
    parameter int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    parameter int CW = $clog2(MAX_NODES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_opcode,
    input  logic [11:0]                   i_node_index,
    input  logic [sshit_pkg::CFG_W-1:0]   i_nodes_in_use,
    input  logic                          i_out_free,
    input  sshit_pkg::t_sts               i_sts,
    output logic                          o_ready,
    output sshit_pkg::t_cmd               o_cmd,
    output logic [AW-1:0]                 o_addr
);

    sshit_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_lim, n_lim;
    logic              r_zero, n_zero;
    logic              accept;
    logic              in_range;

    assign accept   = i_valid && (r_state == sshit_pkg::S_IDLE);
    assign in_range = {20'b0, i_node_index} < 32'(MAX_NODES);
    assign o_ready  = (r_state == sshit_pkg::S_IDLE);
    assign o_addr   = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sshit_pkg::S_IDLE;
            r_idx   <= '0;
            r_lim   <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_lim   <= n_lim;
            r_zero  <= n_zero;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_lim   = r_lim;
        n_zero  = r_zero;
        o_cmd   = '0;
        unique case (r_state)
            sshit_pkg::S_IDLE: begin
                if (accept && (i_opcode == sshit_pkg::OP_LOAD)) begin
                    o_cmd.load_we = in_range;
                end else if (accept) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_zero      = 1'b0;
                    // Counts above the table size test the whole table.
                    n_lim = (32'(i_nodes_in_use) > 32'(MAX_NODES)) ?
                            CW'(MAX_NODES) : CW'(i_nodes_in_use);
                    n_state = sshit_pkg::S_DSQ;
                end
            end
            sshit_pkg::S_DSQ: begin
                o_cmd.dsq_en = 1'b1;
                n_state      = sshit_pkg::S_DEN;
            end
            sshit_pkg::S_DEN: begin
                o_cmd.den_en = 1'b1;
                n_state      = sshit_pkg::S_CHECK;
            end
            sshit_pkg::S_CHECK: begin
                if (i_sts.den_zero) begin
                    n_zero  = 1'b1;
                    n_state = sshit_pkg::S_RESP;
                end else if (r_lim == '0) begin
                    n_state = sshit_pkg::S_RESP;
                end else begin
                    n_state = sshit_pkg::S_RUN;
                end
            end
            sshit_pkg::S_RUN: begin
                o_cmd.issue = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (r_idx == r_lim - 1'b1) begin
                    n_state = sshit_pkg::S_DRAIN;
                end
            end
            sshit_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = sshit_pkg::S_RESP;
                end
            end
            sshit_pkg::S_RESP: begin
                if (i_out_free) begin
                    o_cmd.resp      = 1'b1;
                    o_cmd.resp_zero = r_zero;
                    n_state         = sshit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sshit_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sshit_dp.sv
`timescale 1ns / 1ps

module sshit_dp #(
    parameter int MAX_NODES = sshit_pkg::DEF_MAX_NODES,
    parameter int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sshit_pkg::t_cmd    i_cmd,
    input  logic [AW-1:0]      i_addr,
    input  logic [11:0]        i_node_index,
    input  logic signed [31:0] i_centre_x,
    input  logic signed [31:0] i_centre_y,
    input  logic signed [31:0] i_centre_z,
    input  logic [30:0]        i_sphere_radius,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    output sshit_pkg::t_sts    o_sts
);

    // Node table: {x, y, z, radius}.
    logic [126:0]       r_mem [MAX_NODES];
    logic [126:0]       r_rd;

    logic signed [31:0] r_s [3];
    logic signed [31:0] r_d [3];
    logic [63:0]        r_dsq [3];
    logic [63:0]        r_den;

    logic               r_va, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [32:0] r_w [3];
    logic [30:0]        r_r1;
    logic signed [64:0] r_pd [3];
    logic [63:0]        r_pw [3];
    logic [61:0]        r_rr2;
    logic signed [66:0] r_num;
    logic [65:0]        r_ww;
    logic [61:0]        r_rr3;
    logic               r_ok4, r_ok5;
    logic [63:0]        r_a [2][3];
    logic [63:0]        r_b [2][2];
    logic [63:0]        r_c00, r_c01, r_c11;
    logic [130:0]       r_lhs, r_rhs;
    logic               r_hit;

    logic signed [31:0] rd_c [3];
    logic [31:0]        d_mag [3];
    logic [31:0]        w_mag [3];
    logic [31:0]        den_p [2];
    logic [31:0]        ww_p [3];
    logic [31:0]        rr_p [2];
    logic [63:0]        n_val;
    logic [130:0]       n_lhs, n_rhs;

    assign rd_c[0] = r_rd[126:95];
    assign rd_c[1] = r_rd[94:63];
    assign rd_c[2] = r_rd[62:31];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_mag[k] = r_d[k][31] ? 32'(-33'(r_d[k])) : r_d[k];
            w_mag[k] = r_w[k][32] ? 32'(-r_w[k]) : r_w[k][31:0];
        end
        den_p[0] = r_den[31:0];
        den_p[1] = r_den[63:32];
        ww_p[0]  = r_ww[31:0];
        ww_p[1]  = r_ww[63:32];
        ww_p[2]  = {30'b0, r_ww[65:64]};
        rr_p[0]  = r_rr3[31:0];
        rr_p[1]  = {2'b0, r_rr3[61:32]};
        n_val    = r_num[63:0];
    end

    // The wide products are rebuilt from their 32-bit partial products.
    always_comb begin
        n_lhs = '0;
        n_rhs = '0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_lhs = n_lhs + (131'(r_a[i][j]) << (32 * (i + j)));
            end
            for (int j = 0; j < 2; j++) begin
                n_rhs = n_rhs + (131'(r_b[i][j]) << (32 * (i + j)));
            end
        end
        n_rhs = n_rhs + 131'(r_c00) + (131'(r_c01) << 33) + (131'(r_c11) << 64);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem[AW'(i_node_index)] <= {i_centre_x, i_centre_y, i_centre_z, i_sphere_radius};
        end
        if (i_cmd.issue) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_s[0] <= i_start_x;
            r_s[1] <= i_start_y;
            r_s[2] <= i_start_z;
            r_d[0] <= i_dir_x;
            r_d[1] <= i_dir_y;
            r_d[2] <= i_dir_z;
        end
        if (i_cmd.dsq_en) begin
            for (int k = 0; k < 3; k++) begin
                r_dsq[k] <= 64'(d_mag[k]) * 64'(d_mag[k]);
            end
        end
        if (i_cmd.den_en) begin
            r_den <= r_dsq[0] + r_dsq[1] + r_dsq[2];
        end

        for (int k = 0; k < 3; k++) begin
            r_w[k]  <= {rd_c[k][31], rd_c[k]} - {r_s[k][31], r_s[k]};
            r_pd[k] <= r_w[k] * r_d[k];
            r_pw[k] <= 64'(w_mag[k]) * 64'(w_mag[k]);
        end
        r_r1  <= r_rd[30:0];
        r_rr2 <= 62'(r_r1) * 62'(r_r1);

        r_num <= 67'(r_pd[0]) + 67'(r_pd[1]) + 67'(r_pd[2]);
        r_ww  <= 66'(r_pw[0]) + 66'(r_pw[1]) + 66'(r_pw[2]);
        r_rr3 <= r_rr2;

        // Projection must fall on the segment: 0 <= num <= den.
        r_ok4 <= !r_num[66] && (r_num[65:0] <= {2'b0, r_den});
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_a[i][j] <= 64'(den_p[i]) * 64'(ww_p[j]);
            end
            for (int j = 0; j < 2; j++) begin
                r_b[i][j] <= 64'(rr_p[i]) * 64'(den_p[j]);
            end
        end
        r_c00 <= 64'(n_val[31:0]) * 64'(n_val[31:0]);
        r_c01 <= 64'(n_val[31:0]) * 64'(n_val[63:32]);
        r_c11 <= 64'(n_val[63:32]) * 64'(n_val[63:32]);

        r_lhs <= n_lhs;
        r_rhs <= n_rhs;
        r_ok5 <= r_ok4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_va <= i_cmd.issue;
            r_v1 <= r_va;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (i_cmd.start) begin
                r_hit <= 1'b0;
            end else if (r_v5 && r_ok5 && (r_lhs <= r_rhs)) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_sts.den_zero  = (r_den == '0);
    assign o_sts.pipe_busy = r_va | r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_sts.hit       = r_hit;

endmodule

FILE: sv/segment_sphere_set_hit_test.sv
`timescale 1ns / 1ps

// Segment against sphere set hit test.
// The input channel carries two kinds of transaction. A load (opcode 0) writes
// one sphere node into the table and gives no result. A query
// (opcode 1) gives a segment start and direction; the block tests the first
// nodes_in_use table entries and returns one result transaction with hit and
// zero_length. nodes_in_use is written through the APB port at address 0.
// A query passes the setup states DSQ, DEN and CHECK, then issues one tested node
// per cycle (one table read port feeds a six-stage test pipeline), then waits
// for the pipeline to drain and writes the output register. A zero direction
// or a zero count skips the node tests. One query is in work at a
// time; input ready is high only while the controller is idle.
// The result sits in an output register, so a stalled receiver does not stop
// loads or the start of the next query; that query's answer waits until the
// register is taken. Reset clears the control state and nodes_in_use; the
// node table is not cleared and must be loaded before a query uses it.
module segment_sphere_set_hit_test #(
    parameter int MAX_NODES = sshit_pkg::DEF_MAX_NODES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sshit_in_if.sink                      i_in,
    sshit_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sshit_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [sshit_pkg::CFG_W-1:0] r_nodes_in_use;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic                        r_out_zero;
    logic                        out_free;
    sshit_pkg::t_cmd             cmd;
    sshit_pkg::t_sts             sts;
    logic [AW-1:0]               addr;

    assign pready   = 1'b1;
    assign prdata   = (paddr == sshit_pkg::ADDR_NODES_IN_USE) ? 32'(r_nodes_in_use) : 32'd0;
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_in_use <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == sshit_pkg::ADDR_NODES_IN_USE)) begin
            r_nodes_in_use <= pwdata[sshit_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.resp) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.resp) begin
            r_out_hit  <= sts.hit && !cmd.resp_zero;
            r_out_zero <= cmd.resp_zero;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_out_hit;
    assign o_out.zero_length = r_out_zero;

    sshit_ctrl #(
        .MAX_NODES (MAX_NODES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .i_opcode       (i_in.opcode[0]),
        .i_node_index   (i_in.node_index),
        .i_nodes_in_use (r_nodes_in_use),
        .i_out_free     (out_free),
        .i_sts          (sts),
        .o_ready        (i_in.ready),
        .o_cmd          (cmd),
        .o_addr         (addr)
    );

    sshit_dp #(
        .MAX_NODES (MAX_NODES),
        .AW        (AW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .i_node_index    (i_in.node_index),
        .i_centre_x      (i_in.centre_x),
        .i_centre_y      (i_in.centre_y),
        .i_centre_z      (i_in.centre_z),
        .i_sphere_radius (i_in.sphere_radius),
        .i_start_x       (i_in.start_x),
        .i_start_y       (i_in.start_y),
        .i_start_z       (i_in.start_z),
        .i_dir_x         (i_in.dir_x),
        .i_dir_y         (i_in.dir_y),
        .i_dir_z         (i_in.dir_z),
        .o_sts           (sts)
    );

    // No node test may still be in flight once the block takes a new transaction.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !sts.pipe_busy)
        else $error("test pipeline busy while input is ready");

    // A zero-length answer never reports a hit.
    a_zero_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.hit && o_out.zero_length))
        else $error("hit reported for a zero-length segment");

    // A result is only written into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.resp |-> (!r_out_valid || o_out.ready))
        else $error("pending result overwritten");

endmodule

FILE: tb/hit_checker.sv
`timescale 1ns / 1ps

module hit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sshit_in_if         i_in,
    sshit_out_if        i_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [sshit_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output int          o_fails,
    output int          o_pending
);
    import sshit_pkg::*;

    typedef struct {
        logic hit;
        logic zero_length;
    } t_answer;

    logic signed [31:0] tbl_x [DEF_MAX_NODES];
    logic signed [31:0] tbl_y [DEF_MAX_NODES];
    logic signed [31:0] tbl_z [DEF_MAX_NODES];
    logic [30:0]        tbl_r [DEF_MAX_NODES];
    logic [CFG_W-1:0]   nodes_in_use;
    t_answer            answer_q[$];

    // Exact integer form of the segment test: scales cancel, no rounding.
    function automatic bit sphere_hit(int slot, logic signed [31:0] sx, sy, sz,
                                      logic signed [31:0] dx, dy, dz,
                                      logic signed [255:0] den);
        logic signed [255:0] wx, wy, wz, num, ww, r2;
        wx = tbl_x[slot];
        wx = wx - sx;
        wy = tbl_y[slot];
        wy = wy - sy;
        wz = tbl_z[slot];
        wz = wz - sz;
        r2 = tbl_r[slot];
        r2 = r2 * r2;
        num = wx * dx + wy * dy + wz * dz;
        ww = wx * wx + wy * wy + wz * wz;
        return num >= 0 && num <= den && den * ww <= num * num + r2 * den;
    endfunction

    function automatic t_answer query_answer(logic signed [31:0] sx, sy, sz,
                                             logic signed [31:0] dx, dy, dz);
        t_answer a;
        logic signed [255:0] den;
        int count;
        den = dx * dx;
        den = den + dy * dy;
        den = den + dz * dz;
        a.hit = 1'b0;
        a.zero_length = (den == 0);
        count = (nodes_in_use > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(nodes_in_use);
        if (!a.zero_length)
            for (int i = 0; i < count; i++)
                if (sphere_hit(i, sx, sy, sz, dx, dy, dz, den))
                    a.hit = 1'b1;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            nodes_in_use <= '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_NODES_IN_USE)
                nodes_in_use <= pwdata[CFG_W-1:0];
            if (i_in.valid && i_in.ready) begin
                if (i_in.opcode == OP_LOAD) begin
                    tbl_x[i_in.node_index] = i_in.centre_x;
                    tbl_y[i_in.node_index] = i_in.centre_y;
                    tbl_z[i_in.node_index] = i_in.centre_z;
                    tbl_r[i_in.node_index] = i_in.sphere_radius;
                end else begin
                    answer_q.push_back(query_answer(i_in.start_x, i_in.start_y,
                        i_in.start_z, i_in.dir_x, i_in.dir_y, i_in.dir_z));
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (answer_q.size() == 0) begin
                    $error("result transaction with no query waiting");
                    o_fails++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_out.hit !== want.hit) begin
                        $error("hit: expected %0b, actual %0b", want.hit, i_out.hit);
                        o_fails++;
                    end
                    if (i_out.zero_length !== want.zero_length) begin
                        $error("zero_length: expected %0b, actual %0b",
                               want.zero_length, i_out.zero_length);
                        o_fails++;
                    end
                end
            end
        end
        o_pending = answer_q.size();
    end

    initial begin
        o_fails = 0;
        o_pending = 0;
    end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sshit_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata, prdata;
    int                 fails, pending;
    int                 send_idle, recv_stall, hold_left;

    logic signed [31:0] node_x [DEF_MAX_NODES];
    logic signed [31:0] node_y [DEF_MAX_NODES];
    logic signed [31:0] node_z [DEF_MAX_NODES];
    bit                 loaded [DEF_MAX_NODES];
    int                 cfg_count;

    sshit_in_if  in_ch ();
    sshit_out_if out_ch ();

    segment_sphere_set_hit_test u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_fails(fails), .o_pending(pending)
    );

    always #1 i_clk = ~i_clk;

    // The receiver honors a long hold-off before its random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom;
        if ($urandom_range(3) == 0)
            return v;
        return v >>> $urandom_range(24, 8);
    endfunction

    task automatic send(logic op, logic [11:0] idx,
                        logic signed [31:0] cx, cy, cz, logic [30:0] r,
                        logic signed [31:0] sx, sy, sz, dx, dy, dz);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.node_index <= idx;
        in_ch.centre_x <= cx;
        in_ch.centre_y <= cy;
        in_ch.centre_z <= cz;
        in_ch.sphere_radius <= r;
        in_ch.start_x <= sx;
        in_ch.start_y <= sy;
        in_ch.start_z <= sz;
        in_ch.dir_x <= dx;
        in_ch.dir_y <= dy;
        in_ch.dir_z <= dz;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == OP_LOAD) begin
            node_x[idx] = cx;
            node_y[idx] = cy;
            node_z[idx] = cz;
            loaded[idx] = 1'b1;
        end
    endtask

    task automatic load_node(logic [11:0] idx, logic signed [31:0] cx, cy, cz,
                             logic [30:0] r);
        send(OP_LOAD, idx, cx, cy, cz, r, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
    endtask

    task automatic query(logic signed [31:0] sx, sy, sz, dx, dy, dz);
        send(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
             sx, sy, sz, dx, dy, dz);
    endtask

    // Waits until every answer has come back, plus room for a trailing load.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Only counts whose slots have all been loaded are allowed.
    task automatic set_count(int want);
        int n;
        n = 0;
        while (n < want && n < DEF_MAX_NODES && loaded[n]) n++;
        cfg_count = (want > DEF_MAX_NODES && n == DEF_MAX_NODES) ? want : n;
        apb_write(ADDR_NODES_IN_USE, cfg_count);
    endtask

    task automatic random_item();
        int k, pick;
        logic signed [31:0] ox, oy, oz;
        pick = $urandom_range(99);
        if (pick < 35) begin
            k = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(19);
            load_node(k, rand_coord(), rand_coord(), rand_coord(),
                      ($urandom_range(1) == 0) ? $urandom : ($urandom >> $urandom_range(20, 4)));
        end else if (pick < 80 && cfg_count > 0) begin
            // Aim the segment across a tested node so that hits are common.
            k = $urandom_range(cfg_count - 1);
            if (k >= DEF_MAX_NODES) k = DEF_MAX_NODES - 1;
            ox = $signed($urandom) >>> $urandom_range(24, 6);
            oy = $signed($urandom) >>> $urandom_range(24, 6);
            oz = $signed($urandom) >>> $urandom_range(24, 6);
            query(node_x[k] - ox, node_y[k] - oy, node_z[k] - oz,
                  2 * ox + ($signed($urandom) >>> 26), 2 * oy, 2 * oz);
        end else if (pick < 85) begin
            query(rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
        end else begin
            query(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic random_phase(int items, int idle, int stall);
        drain();
        set_count($urandom_range(16));
        send_idle = idle;
        recv_stall = stall;
        repeat (items) random_item();
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_left = 0;
        send_idle = 0;
        recv_stall = 0;
        cfg_count = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_LOAD;
        in_ch.node_index = '0;
        in_ch.centre_x = '0;
        in_ch.centre_y = '0;
        in_ch.centre_z = '0;
        in_ch.sphere_radius = '0;
        in_ch.start_x = '0;
        in_ch.start_y = '0;
        in_ch.start_z = '0;
        in_ch.dir_x = '0;
        in_ch.dir_y = '0;
        in_ch.dir_z = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, zero direction, extremes and boundaries.
        query(0, 0, 0, 32'sh10000, 0, 0);
        query(5, -5, 7, 0, 0, 0);
        load_node(0, 0, 0, 0, 31'h7FFF_FFFF);
        load_node(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        load_node(2, 0, 32'sh0001_0000, 0, 31'h0001_0000);
        load_node(3, 32'sh0004_0000, 0, 0, 31'h0000_8000);
        load_node(4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        drain();
        set_count(4);
        query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        drain();
        set_count(0);
        load_node(0, 32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000, 1);
        drain();
        set_count(4);
        // Touching node 2 exactly at distance r, then before and beyond the segment.
        query(32'sh0000_0000, 0, 0, 32'sh0001_0000, 0, 0);
        query(32'sh0005_0000, 0, 0, 32'sh0001_0000, 0, 0);
        query(32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 0);
        query(32'sh0003_8000, 0, 0, 32'sh0001_0000, 0, 0);
        query(32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 0);
        query(32'sh0005_0000, 0, 0, 32'shFFFF_0000, 0, 0);

        random_phase(30, 0, 0);
        random_phase(30, 59, 0);
        random_phase(30, 0, 59);
        random_phase(30, 18, 18);

        // The receiver holds off while queries keep coming, then all drains.
        drain();
        set_count(8);
        send_idle = 0;
        recv_stall = 0;
        hold_left = 400;
        repeat (8) random_item();
        drain();

        // Full table, then a count beyond the table.
        for (int i = 0; i < DEF_MAX_NODES; i++)
            load_node(i, rand_coord(), rand_coord(), rand_coord(), $urandom >> 8);
        drain();
        set_count(4096);
        repeat (3) random_item();
        drain();
        set_count(8191);
        recv_stall = 30;
        repeat (3) random_item();
        drain();

        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
